// File: hdl/cms_pkg.sv
package cms_pkg;

   // Drive mode codes.
   localparam logic [2:0] MODE_AUTO    = 3'd0;
   localparam logic [2:0] MODE_FAST    = 3'd1;
   localparam logic [2:0] MODE_SLOW    = 3'd2;
   localparam logic [2:0] MODE_ALIGN   = 3'd3;
   localparam logic [2:0] MODE_POWERED = 3'd4;
   localparam logic [2:0] MODE_STEP    = 3'd5;
   localparam logic [2:0] MODE_RAMP    = 3'd6;

   // Remote switch codes.
   localparam logic [1:0] SW_UNKNOWN = 2'd0;
   localparam logic [1:0] SW_UP      = 2'd1;
   localparam logic [1:0] SW_MIDDLE  = 2'd2;
   localparam logic [1:0] SW_DOWN    = 2'd3;

   // Key bit positions.
   localparam int KEY_SPIN = 0;
   localparam int KEY_RAMP = 1;
   localparam int KEY_STEP = 2;

   // Register indexes.
   localparam logic [1:0] CSR_STUCK_RATE_FAST     = 2'd0;
   localparam logic [1:0] CSR_STUCK_RATE_SLOW     = 2'd1;
   localparam logic [1:0] CSR_STUCK_CONFIRM_TICKS = 2'd2;
   localparam logic [1:0] CSR_RECOVERY_TICKS      = 2'd3;

   // Register reset values.
   localparam logic [14:0] STUCK_RATE_FAST_RST     = 15'd492;
   localparam logic [14:0] STUCK_RATE_SLOW_RST     = 15'd246;
   localparam logic [15:0] STUCK_CONFIRM_TICKS_RST = 16'd300;
   localparam logic [15:0] RECOVERY_TICKS_RST      = 16'd1000;

   localparam int COUNT_WIDTH_DEF = 16;

   localparam int REQ_DATA_WIDTH = 32;
   localparam int RSP_DATA_WIDTH = 8;

   typedef struct packed {
      logic [1:0]  right_switch;
      logic [1:0]  left_switch;
      logic [2:0]  keys;
      logic        nav_enable;
      logic        nav_command_finite;
      logic [2:0]  nav_mode;
      logic        imu_valid;
      logic signed [15:0] yaw_rate;
   } cms_req_type;

   typedef struct packed {
      logic [14:0] stuck_rate_fast;
      logic [14:0] stuck_rate_slow;
      logic [15:0] stuck_confirm_ticks;
      logic [15:0] recovery_ticks;
   } cms_cfg_type;

   // Mode state apart from the two watchdog counters.
   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] prev_right_switch;
      logic [2:0] prev_keys;
      logic       spin_dir;
      logic [2:0] saved_mode;
   } cms_state_type;

   typedef struct packed {
      logic       recovering;
      logic       controls_reset;
      logic       spin_forward;
      logic [2:0] drive_mode;
   } cms_result_type;

endpackage

// File: hdl/cms_step.sv
module cms_step
   import cms_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  cms_req_type             req,
   input  cms_cfg_type             cfg,
   input  cms_state_type           state,
   input  logic [COUNT_WIDTH-1:0]  stuck_count,
   input  logic [COUNT_WIDTH-1:0]  recovery_count,
   output cms_state_type           state_in,
   output logic [COUNT_WIDTH-1:0]  stuck_count_in,
   output logic [COUNT_WIDTH-1:0]  recovery_count_in,
   output cms_result_type          result
);

   localparam logic [31:0] CNT_MAX = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   logic [2:0]             rise;
   logic                   safe_reset;
   logic [2:0]             edge_mode;
   logic                   edge_flip;
   logic [2:0]             cmd_mode;
   logic [16:0]            yaw_mag;
   logic [14:0]            threshold;
   logic [COUNT_WIDTH-1:0] rec_dec;
   logic [COUNT_WIDTH-1:0] stuck_inc;
   logic [COUNT_WIDTH-1:0] recovery_load;

   assign rise = req.keys & ~state.prev_keys;

   assign safe_reset = (req.left_switch == SW_UNKNOWN) || (req.right_switch == SW_UNKNOWN) ||
                       ((req.left_switch == SW_DOWN) && (req.right_switch == SW_DOWN));

   // Magnitude of the yaw rate; the most negative code gives 32768.
   assign yaw_mag = req.yaw_rate[15] ? (17'd0 - {req.yaw_rate[15], req.yaw_rate})
                                     : {1'b0, req.yaw_rate};

   assign rec_dec   = recovery_count - COUNT_WIDTH'(1);
   assign stuck_inc = (32'(stuck_count) < CNT_MAX) ? stuck_count + COUNT_WIDTH'(1)
                                                   : stuck_count;
   assign recovery_load = (32'(cfg.recovery_ticks) > CNT_MAX) ? COUNT_WIDTH'(CNT_MAX)
                                                              : COUNT_WIDTH'(cfg.recovery_ticks);

   // Switch and key edges; the first one that matches wins.
   always_comb begin
      edge_mode = state.mode;
      edge_flip = 1'b0;
      if (state.prev_right_switch == SW_MIDDLE && req.right_switch == SW_DOWN) begin
         if (state.mode != MODE_FAST) begin
            edge_mode = MODE_FAST;
            edge_flip = 1'b1;
         end else begin
            edge_mode = MODE_STEP;
         end
      end else if (rise[KEY_SPIN]) begin
         if (state.mode != MODE_FAST) begin
            edge_mode = MODE_FAST;
            edge_flip = 1'b1;
         end else begin
            edge_mode = MODE_AUTO;
         end
      end else if (rise[KEY_RAMP]) begin
         edge_mode = (state.mode != MODE_RAMP) ? MODE_RAMP : MODE_AUTO;
      end else if (rise[KEY_STEP]) begin
         edge_mode = (state.mode != MODE_STEP) ? MODE_STEP : MODE_AUTO;
      end
   end

   // Navigation override; a code past the last mode means nothing and is ignored.
   assign cmd_mode = (req.nav_enable && req.nav_command_finite && req.nav_mode <= MODE_RAMP) ?
                     req.nav_mode : edge_mode;

   assign threshold = (cmd_mode == MODE_FAST) ? cfg.stuck_rate_fast : cfg.stuck_rate_slow;

   // Next state: safe reset, left switch hold, or edges followed by the watchdog.
   always_comb begin
      state_in                   = state;
      state_in.prev_right_switch = req.right_switch;
      state_in.prev_keys         = req.keys;
      stuck_count_in             = stuck_count;
      recovery_count_in          = recovery_count;

      if (safe_reset) begin
         state_in.mode     = MODE_ALIGN;
         stuck_count_in    = '0;
         recovery_count_in = '0;
      end else if (req.left_switch != SW_DOWN) begin
         state_in.spin_dir = state.spin_dir ^ edge_flip;
         state_in.mode     = cmd_mode;
         if (recovery_count != '0) begin
            recovery_count_in = rec_dec;
            state_in.mode     = (rec_dec == '0) ? state.saved_mode : MODE_POWERED;
            stuck_count_in    = '0;
         end else if ((cmd_mode != MODE_FAST && cmd_mode != MODE_SLOW) || !req.imu_valid) begin
            stuck_count_in = '0;
         end else if (yaw_mag >= {2'b00, threshold}) begin
            stuck_count_in = '0;
         end else if (32'(stuck_inc) >= 32'(cfg.stuck_confirm_ticks)) begin
            state_in.saved_mode = cmd_mode;
            state_in.mode       = MODE_POWERED;
            recovery_count_in   = recovery_load;
            stuck_count_in      = '0;
         end else begin
            stuck_count_in = stuck_inc;
         end
      end
   end

   assign result.drive_mode     = state_in.mode;
   assign result.spin_forward   = state_in.spin_dir;
   assign result.controls_reset = safe_reset;
   assign result.recovering     = (recovery_count_in != '0);

endmodule

// File: hdl/chassis_mode_sequencer.sv
// Channel  Direction  Ports                          Payload
// req      in         req_tvalid/tready/tdata[31:0]  switches, keys, navigation, yaw rate
// rsp      out        rsp_tvalid/tready/tdata[7:0]   drive mode, spin, reset and recovery flags
// csr      in         csr_we/csr_index/csr_wdata     watchdog thresholds and tick counts
//
// One beat per cycle while the output register can take it: the whole tick is computed
// combinationally from the accepted req beat and the mode state, and the result appears
// in the output register in the next cycle.
// A req beat is taken whenever the output register is empty or is being drained.
// Reset is synchronous; it empties the output register and loads the register defaults.
module chassis_mode_sequencer
   import cms_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] right_switch, [3:2] left_switch, [4] key_spin, [5] key_ramp, [6] key_step,
   // [7] nav_enable, [8] nav_command_finite, [11:9] nav_mode, [12] imu_valid,
   // [28:13] yaw_rate, [31:29] zero
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] drive_mode, [3] spin_forward, [4] controls_reset, [5] recovering, [7:6] zero
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cms_req_type            req;
   cms_cfg_type            cfg_ff;
   cms_state_type          state_ff, state_in;
   logic [COUNT_WIDTH-1:0] stuck_count_ff, stuck_count_in;
   logic [COUNT_WIDTH-1:0] recovery_count_ff, recovery_count_in;
   cms_result_type         result_in, result_ff;
   logic                   rsp_valid_ff;
   logic                   req_fire;

   // Unpack the request beat.
   assign req.right_switch       = req_tdata[1:0];
   assign req.left_switch        = req_tdata[3:2];
   assign req.keys               = req_tdata[6:4];
   assign req.nav_enable         = req_tdata[7];
   assign req.nav_command_finite = req_tdata[8];
   assign req.nav_mode           = req_tdata[11:9];
   assign req.imu_valid          = req_tdata[12];
   assign req.yaw_rate           = req_tdata[28:13];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stuck_rate_fast     <= STUCK_RATE_FAST_RST;
         cfg_ff.stuck_rate_slow     <= STUCK_RATE_SLOW_RST;
         cfg_ff.stuck_confirm_ticks <= STUCK_CONFIRM_TICKS_RST;
         cfg_ff.recovery_ticks      <= RECOVERY_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STUCK_RATE_FAST:     cfg_ff.stuck_rate_fast     <= csr_wdata[14:0];
            CSR_STUCK_RATE_SLOW:     cfg_ff.stuck_rate_slow     <= csr_wdata[14:0];
            CSR_STUCK_CONFIRM_TICKS: cfg_ff.stuck_confirm_ticks <= csr_wdata;
            CSR_RECOVERY_TICKS:      cfg_ff.recovery_ticks      <= csr_wdata;
            default: ;
         endcase
      end
   end

   cms_step #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) u_step (
      .req              (req),
      .cfg              (cfg_ff),
      .state            (state_ff),
      .stuck_count      (stuck_count_ff),
      .recovery_count   (recovery_count_ff),
      .state_in         (state_in),
      .stuck_count_in   (stuck_count_in),
      .recovery_count_in(recovery_count_in),
      .result           (result_in)
   );

   // Mode state advances once per accepted beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode              <= MODE_ALIGN;
         state_ff.prev_right_switch <= SW_UNKNOWN;
         state_ff.prev_keys         <= '0;
         state_ff.spin_dir          <= 1'b1;
         state_ff.saved_mode        <= MODE_AUTO;
         stuck_count_ff             <= '0;
         recovery_count_ff          <= '0;
      end else if (req_fire) begin
         state_ff          <= state_in;
         stuck_count_ff    <= stuck_count_in;
         recovery_count_ff <= recovery_count_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, result_ff};

endmodule

// File: hdl/cms_checker.sv
module cms_checker
   import cms_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // The output register is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat offered right after reset");

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // A safe reset tick always reports alignment with no recovery running.
   a_reset_align: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[2:0] == MODE_ALIGN && !rsp_tdata[5])
      else $error("safe reset without alignment");

   // An accepted beat with an unknown right switch yields a safe reset result next.
   a_unknown_switch: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tdata[1:0] == SW_UNKNOWN |=> rsp_tvalid && rsp_tdata[4])
      else $error("unknown switch did not force safe reset");

   // The mode code never leaves the defined set.
   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] <= MODE_RAMP)
      else $error("undefined drive mode");

endmodule

bind chassis_mode_sequencer cms_checker u_cms_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
